@@ src/page_replacement_engine_assert.svh @@
// Assertion macros for the page replacement engine
`ifndef PAGE_REPLACEMENT_ENGINE_ASSERT_SVH
`define PAGE_REPLACEMENT_ENGINE_ASSERT_SVH

// Clocked property, switched off while reset is applied
`define PRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds during reset
`define PRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pre_pkg.sv @@
// Shared types and constants for the page replacement engine
package pre_pkg;

  // Build-time defaults
  localparam int unsigned FramesDef   = 8;
  localparam int unsigned PageBitsDef = 16;

  // Fixed field widths
  localparam int unsigned StampW  = 32;
  localparam int unsigned FaultW  = 32;
  localparam int unsigned PageInW = 16;
  localparam int unsigned FrameOutW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 2;

  // Configuration register indices
  localparam logic [CfgIdxW-1:0] RegPolicy = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrames = 1'b1;

  // Frames managed after reset
  localparam logic [CfgDataW-1:0] FramesRst = 4'd8;

  // Replacement policies
  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2
  } pre_policy_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } pre_state_e;

endpackage

@@ src/pre_cell.sv @@
// One page frame: holds page, valid and stamp, folds its entry into the scan record
module pre_cell #(
  parameter int unsigned Frames   = pre_pkg::FramesDef,
  parameter int unsigned PageBits = pre_pkg::PageBitsDef,
  parameter int unsigned Idx      = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [PageBits-1:0]               page_i,
  input  logic [$clog2(Frames+1)-1:0]       n_i,
  input  logic [((Frames > 1) ? $clog2(Frames) : 1)-1:0] fifo_slot_i,
  input  logic [((Frames > 1) ? $clog2(Frames) : 1)+PageBits+pre_pkg::StampW:0] wr_i,
  input  logic [3*((Frames > 1) ? $clog2(Frames) : 1)+2*pre_pkg::StampW+2*PageBits+2:0] scan_i,
  output logic [3*((Frames > 1) ? $clog2(Frames) : 1)+2*pre_pkg::StampW+2*PageBits+2:0] scan_o
);

  localparam int unsigned IdxW = (Frames > 1) ? $clog2(Frames) : 1;
  localparam int unsigned NW   = $clog2(Frames + 1);

  typedef struct packed {
    logic                       found;
    logic [IdxW-1:0]            found_idx;
    logic [pre_pkg::StampW-1:0] found_stamp;
    logic                       empty;
    logic [IdxW-1:0]            empty_idx;
    logic                       min_valid;
    logic [pre_pkg::StampW-1:0] min_stamp;
    logic [IdxW-1:0]            min_idx;
    logic [PageBits-1:0]        min_page;
    logic [PageBits-1:0]        head_page;
  } scan_t;

  typedef struct packed {
    logic                       en;
    logic [IdxW-1:0]            idx;
    logic [PageBits-1:0]        page;
    logic [pre_pkg::StampW-1:0] stamp;
  } wr_t;

  scan_t                      rec_in, rec_d, rec_q;
  wr_t                        wr;
  logic                       valid_q;
  logic [PageBits-1:0]        page_q;
  logic [pre_pkg::StampW-1:0] stamp_q;
  logic                       active;
  logic                       my_write;

  assign rec_in   = scan_i;
  assign wr       = wr_i;
  assign scan_o   = rec_q;
  assign active   = NW'(Idx) < n_i;
  assign my_write = wr.en && (wr.idx == IdxW'(Idx));

  // Fold this frame into the record passed down the row
  always_comb begin
    rec_d = rec_in;
    if (active) begin
      if (valid_q && (page_q == page_i) && !rec_in.found) begin
        rec_d.found       = 1'b1;
        rec_d.found_idx   = IdxW'(Idx);
        rec_d.found_stamp = stamp_q;
      end
      if (!valid_q && !rec_in.empty) begin
        rec_d.empty     = 1'b1;
        rec_d.empty_idx = IdxW'(Idx);
      end
      // strict less keeps ties on the lower frame
      if (!rec_in.min_valid || (stamp_q < rec_in.min_stamp)) begin
        rec_d.min_valid = 1'b1;
        rec_d.min_stamp = stamp_q;
        rec_d.min_idx   = IdxW'(Idx);
        rec_d.min_page  = page_q;
      end
      if (fifo_slot_i == IdxW'(Idx)) begin
        rec_d.head_page = page_q;
      end
    end
  end

  // Record stage towards the next cell
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  // Frame occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (my_write) begin
      valid_q <= 1'b1;
    end
  end

  // Frame contents
  always_ff @(posedge clk_i) begin
    if (my_write) begin
      page_q  <= wr.page;
      stamp_q <= wr.stamp;
    end
  end

endmodule

@@ src/page_replacement_engine.sv @@
// Page replacement engine top level: sequencer, configuration and result register
//
// Usage: each item on the s_axis channel is one page reference (tdata holds
// page_number). The page is looked up among the frames in use; on a miss it
// fills the lowest empty frame or replaces a victim chosen by the policy
// (FIFO head, lowest LRU stamp, lowest LFU count, ties to the lowest frame).
// One result item per reference leaves on m_axis.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 policy,
// 1 frames_in_use) and cfg_data_i; cfg_ready_o is always high. Write only
// while the block is idle.
// Timing: the lookup runs down a row of FRAMES frame cells, one cell per
// cycle, then an update step in ST_WRITE writes the chosen frame and loads
// the result register. A new item is accepted only in ST_IDLE, so the block
// does not take the next item until the current one has been written.
// Stalls: the result waits in an output register; the next item is accepted
// and scanned meanwhile, and its update waits until that register is free.
// Reset: all frames empty, fault count, reference clock and FIFO head cleared,
// policy FIFO, eight frames in use. Frame pages and stamps are only read once
// written, so no clearing pass is needed.
module page_replacement_engine #(
  parameter int unsigned FRAMES    = pre_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = pre_pkg::PageBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pre_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pre_pkg::CfgDataW-1:0]    cfg_data_i,
  // page references
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pre_pkg::PageInW-1:0]     s_axis_tdata,  // [15:0] page_number
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] frame_index, [18:3] evicted_page, [50:19] fault_total, [55:51] zero
  output logic [pre_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] hit, [1] evicted_valid
  output logic [pre_pkg::OutUserW-1:0]    m_axis_tuser
);

  `include "page_replacement_engine_assert.svh"

  localparam int unsigned IdxW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW    = $clog2(FRAMES + 1);
  localparam int unsigned CW    = (NW > pre_pkg::CfgDataW) ? NW : pre_pkg::CfgDataW;
  localparam int unsigned StW   = pre_pkg::StampW;

  typedef struct packed {
    logic                found;
    logic [IdxW-1:0]     found_idx;
    logic [StW-1:0]      found_stamp;
    logic                empty;
    logic [IdxW-1:0]     empty_idx;
    logic                min_valid;
    logic [StW-1:0]      min_stamp;
    logic [IdxW-1:0]     min_idx;
    logic [PAGE_BITS-1:0] min_page;
    logic [PAGE_BITS-1:0] head_page;
  } scan_t;

  typedef struct packed {
    logic                 en;
    logic [IdxW-1:0]      idx;
    logic [PAGE_BITS-1:0] page;
    logic [StW-1:0]       stamp;
  } wr_t;

  // control state
  pre_pkg::pre_state_e            state_q, state_d;
  logic [IdxW-1:0]                cnt_q;
  logic [1:0]                     policy_q;
  logic [pre_pkg::CfgDataW-1:0]   frames_q;
  logic [IdxW-1:0]                head_q, head_d;
  logic [pre_pkg::FaultW-1:0]     fault_q, fault_d;
  logic [StW-1:0]                 clock_q;
  logic                           out_valid_q;

  // payload
  logic [PAGE_BITS-1:0]           page_q;
  logic                           hit_q, evict_q;
  logic [pre_pkg::FrameOutW-1:0]  frame_out_q;
  logic [pre_pkg::PageInW-1:0]    old_out_q;

  // scan row
  scan_t                          rec [FRAMES];
  scan_t                          last;
  wr_t                            wr;

  pre_pkg::pre_policy_e           pol;
  logic [CW-1:0]                  frames_ext;
  logic [NW-1:0]                  n_act;
  logic [IdxW-1:0]                fifo_slot;
  logic                           in_fire, wr_fire, cfg_fire;
  logic                           dec_hit, dec_evict;
  logic [IdxW-1:0]                dec_slot;
  logic [PAGE_BITS-1:0]           dec_old;
  logic [PAGE_BITS+pre_pkg::PageInW-1:0] page_in_ext;
  logic [PAGE_BITS+pre_pkg::PageInW-1:0] old_ext;
  logic [IdxW+pre_pkg::FrameOutW-1:0]    slot_ext;

  // Effective policy: the unused code acts as FIFO
  always_comb begin
    unique case (policy_q)
      pre_pkg::POL_LRU: pol = pre_pkg::POL_LRU;
      pre_pkg::POL_LFU: pol = pre_pkg::POL_LFU;
      default:          pol = pre_pkg::POL_FIFO;
    endcase
  end

  // Frames in use, clamped to 1..FRAMES
  assign frames_ext = CW'(frames_q);
  always_comb begin
    priority if (frames_ext == '0) begin
      n_act = NW'(1);
    end else if (frames_ext > CW'(FRAMES)) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(frames_ext);
    end
  end

  // FIFO head outside the frames in use reads as frame zero
  assign fifo_slot = (NW'(head_q) < n_act) ? head_q : '0;

  // Row of frame cells
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    scan_t cell_in;
    if (k == 0) begin : g_seed
      assign cell_in = '0;
    end else begin : g_link
      assign cell_in = rec[k-1];
    end
    pre_cell #(
      .Frames   (FRAMES),
      .PageBits (PAGE_BITS),
      .Idx      (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .page_i      (page_q),
      .n_i         (n_act),
      .fifo_slot_i (fifo_slot),
      .wr_i        (wr),
      .scan_i      (cell_in),
      .scan_o      (rec[k])
    );
  end
  assign last = rec[FRAMES-1];

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == pre_pkg::ST_IDLE);
    wr_fire       = (state_q == pre_pkg::ST_WRITE) && (!out_valid_q || m_axis_tready);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pre_pkg::ST_IDLE: begin
        if (in_fire) state_d = pre_pkg::ST_SCAN;
      end
      pre_pkg::ST_SCAN: begin
        if (cnt_q == IdxW'(FRAMES - 1)) state_d = pre_pkg::ST_WRITE;
      end
      pre_pkg::ST_WRITE: begin
        if (wr_fire) state_d = pre_pkg::ST_IDLE;
      end
      default: state_d = pre_pkg::ST_IDLE;
    endcase
  end

  // Decision from the finished scan record
  always_comb begin
    dec_hit   = last.found;
    dec_evict = 1'b0;
    dec_old   = '0;
    dec_slot  = last.found_idx;
    head_d    = head_q;
    fault_d   = fault_q;
    wr.en     = 1'b0;
    wr.idx    = last.found_idx;
    wr.page   = page_q;
    wr.stamp  = clock_q;
    if (last.found) begin
      // hit: LRU restamps, LFU counts up saturating, FIFO leaves it
      unique case (pol)
        pre_pkg::POL_LRU: begin
          wr.en    = wr_fire;
          wr.stamp = clock_q;
        end
        pre_pkg::POL_LFU: begin
          wr.en    = wr_fire;
          wr.stamp = (last.found_stamp == '1) ? last.found_stamp
                                              : last.found_stamp + StW'(1);
        end
        default: wr.en = 1'b0;
      endcase
    end else begin
      if (fault_q != '1) fault_d = fault_q + pre_pkg::FaultW'(1);
      if (last.empty) begin
        dec_slot = last.empty_idx;
      end else begin
        dec_evict = 1'b1;
        if (pol == pre_pkg::POL_FIFO) begin
          dec_slot = fifo_slot;
          dec_old  = last.head_page;
          head_d   = ((NW'(fifo_slot) + NW'(1)) < n_act) ? fifo_slot + IdxW'(1) : '0;
        end else begin
          dec_slot = last.min_idx;
          dec_old  = last.min_page;
        end
      end
      wr.en    = wr_fire;
      wr.idx   = dec_slot;
      wr.stamp = (pol == pre_pkg::POL_LFU) ? '0 : clock_q;
    end
  end

  // Field width adaption
  assign page_in_ext = {{PAGE_BITS{1'b0}}, s_axis_tdata};
  assign old_ext     = {{pre_pkg::PageInW{1'b0}}, dec_old};
  assign slot_ext    = {{pre_pkg::FrameOutW{1'b0}}, dec_slot};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pre_pkg::ST_IDLE;
      cnt_q       <= '0;
      policy_q    <= pre_pkg::POL_FIFO;
      frames_q    <= pre_pkg::FramesRst;
      head_q      <= '0;
      fault_q     <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pre_pkg::ST_SCAN) begin
        cnt_q <= cnt_q + IdxW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (cfg_fire) begin
        unique case (cfg_index_i)
          pre_pkg::RegPolicy: policy_q <= cfg_data_i[1:0];
          pre_pkg::RegFrames: frames_q <= cfg_data_i;
        endcase
      end
      if (wr_fire) begin
        head_q  <= head_d;
        fault_q <= fault_d;
        clock_q <= clock_q + StW'(1);
      end
      if (wr_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Reference and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      page_q <= page_in_ext[PAGE_BITS-1:0];
    end
    if (wr_fire) begin
      hit_q       <= dec_hit;
      evict_q     <= dec_evict;
      frame_out_q <= slot_ext[pre_pkg::FrameOutW-1:0];
      old_out_q   <= old_ext[pre_pkg::PageInW-1:0];
    end
  end

  // Result channel; fault_q already holds this item's count once loaded
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, fault_q, old_out_q, frame_out_q};
  assign m_axis_tuser  = {evict_q, hit_q};

  // Checks
  `PRE_ASSERT(a_write_gives_result, clk_i, rst_ni, wr_fire |=> m_axis_tvalid, "update without result")
  `PRE_ASSERT(a_hit_no_evict, clk_i, rst_ni, (wr_fire && dec_hit) |-> !dec_evict, "hit evicted a page")
  `PRE_ASSERT(a_fault_monotonic, clk_i, rst_ni, 1'b1 |=> (fault_q >= $past(fault_q)), "fault count fell")
  `PRE_ASSERT_ALWAYS(a_no_accept_busy, clk_i, (state_q != pre_pkg::ST_IDLE) |-> !s_axis_tready, "item taken mid scan")

endmodule

@@ test/page_ref_checker.sv @@
// Result checker for the page replacement engine: tracks frames, predicts and compares
`timescale 1ns / 1ps

module page_ref_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration channel as seen at the block
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [pre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pre_pkg::CfgDataW-1:0] cfg_data_i,
  // page references
  input  logic                         ref_valid_i,
  input  logic                         ref_ready_i,
  input  logic [pre_pkg::PageInW-1:0]  ref_page_i,
  // results
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  // [2:0] frame, [18:3] evicted page, [50:19] faults
  input  logic [pre_pkg::OutDataW-1:0] res_data_i,
  input  logic [pre_pkg::OutUserW-1:0] res_user_i,  // [0] hit, [1] evicted_valid
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           hits_o
);

  typedef struct packed {
    logic                        hit;
    logic [2:0]                  frame;
    logic                        evicted;
    logic [pre_pkg::PageInW-1:0] victim_page;
    logic [pre_pkg::FaultW-1:0]  faults;
  } page_outcome_t;

  // Shadow copy of the frame table and counters
  logic [pre_pkg::PageInW-1:0] slot_page  [pre_pkg::FramesDef];
  logic                        slot_full  [pre_pkg::FramesDef];
  logic [pre_pkg::StampW-1:0]  slot_stamp [pre_pkg::FramesDef];
  logic [2:0]                  rr_head;
  logic [pre_pkg::FaultW-1:0]  fault_cnt;
  logic [pre_pkg::StampW-1:0]  ref_clock;
  logic [1:0]                  pol_reg;
  logic [3:0]                  frames_reg;

  page_outcome_t outcome_q [$];
  int            mismatches;
  int            result_cnt;
  int            hit_cnt;

  // Apply one reference to the shadow table and return what the block should report
  function automatic page_outcome_t resolve_reference(input logic [pre_pkg::PageInW-1:0] pg);
    page_outcome_t        res;
    pre_pkg::pre_policy_e pol;
    int unsigned          n;
    int unsigned          slot;
    int unsigned          i;
    bit                   found;
    bit                   empty;
    res   = '0;
    found = 1'b0;
    empty = 1'b0;
    slot  = 0;
    // zero frames means one, anything beyond the build means all of them
    if (frames_reg == 0) n = 1;
    else if (frames_reg > pre_pkg::FramesDef) n = pre_pkg::FramesDef;
    else n = frames_reg;
    // the spare policy code behaves as FIFO
    if (pol_reg == pre_pkg::POL_LRU) pol = pre_pkg::POL_LRU;
    else if (pol_reg == pre_pkg::POL_LFU) pol = pre_pkg::POL_LFU;
    else pol = pre_pkg::POL_FIFO;

    for (i = 0; i < n; i++) begin
      if (!found && slot_full[i] && slot_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end

    if (found) begin
      if (pol == pre_pkg::POL_LRU) begin
        slot_stamp[slot] = ref_clock;
      end else if (pol == pre_pkg::POL_LFU && slot_stamp[slot] != '1) begin
        slot_stamp[slot] = slot_stamp[slot] + 1;
      end
    end else begin
      if (fault_cnt != '1) fault_cnt = fault_cnt + 1;
      for (i = 0; i < n; i++) begin
        if (!empty && !slot_full[i]) begin
          slot  = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        if (pol == pre_pkg::POL_FIFO) begin
          // a head left outside a shrunk frame range restarts at frame 0
          slot    = (rr_head < n) ? rr_head : 0;
          rr_head = (slot + 1 < n) ? 3'(slot + 1) : 3'd0;
        end else begin
          // lowest stamp wins, ties to the lowest frame
          slot = 0;
          for (i = 1; i < n; i++) begin
            if (slot_stamp[i] < slot_stamp[slot]) slot = i;
          end
        end
        res.evicted     = 1'b1;
        res.victim_page = slot_page[slot];
      end
      slot_page[slot]  = pg;
      slot_full[slot]  = 1'b1;
      slot_stamp[slot] = (pol == pre_pkg::POL_LFU) ? '0 : ref_clock;
    end

    ref_clock   = ref_clock + 1;
    res.hit     = found;
    res.frame   = 3'(slot);
    res.faults  = fault_cnt;
    return res;
  endfunction

  task automatic flag_field(input string field, input longint unsigned exp_v,
                            input longint unsigned act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
               $realtime, result_cnt, field, exp_v, act_v);
    end
  endtask

  // Watch all three channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    page_outcome_t want;
    page_outcome_t got;
    if (!rst_ni) begin
      for (int k = 0; k < pre_pkg::FramesDef; k++) begin
        slot_page[k]  = '0;
        slot_full[k]  = 1'b0;
        slot_stamp[k] = '0;
      end
      rr_head      = '0;
      fault_cnt    = '0;
      ref_clock    = '0;
      pol_reg      = pre_pkg::POL_FIFO;
      frames_reg   = pre_pkg::FramesRst;
      outcome_q.delete();
      mismatches   = 0;
      result_cnt   = 0;
      hit_cnt      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      hits_o       <= 0;
    end else begin
      // results first: one arriving now belongs to an older reference
      if (res_valid_i && res_ready_i) begin
        got = {res_user_i[0], res_data_i[2:0], res_user_i[1], res_data_i[18:3],
               res_data_i[50:19]};
        result_cnt++;
        if (got.hit) hit_cnt++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d arrived with no reference outstanding",
                     $realtime, result_cnt);
          end
        end else begin
          want = outcome_q.pop_front();
          if (got.hit != want.hit) flag_field("hit", want.hit, got.hit);
          if (got.frame != want.frame) flag_field("frame_index", want.frame, got.frame);
          if (got.evicted != want.evicted) begin
            flag_field("evicted_valid", want.evicted, got.evicted);
          end
          if (got.victim_page != want.victim_page) begin
            flag_field("evicted_page", want.victim_page, got.victim_page);
          end
          if (got.faults != want.faults) flag_field("fault_total", want.faults, got.faults);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pre_pkg::RegPolicy: pol_reg    = cfg_data_i[1:0];
          pre_pkg::RegFrames: frames_reg = cfg_data_i;
          default: ;
        endcase
      end

      if (ref_valid_i && ref_ready_i) outcome_q.push_back(resolve_reference(ref_page_i));

      fail_count_o <= mismatches;
      pending_o    <= outcome_q.size();
      results_o    <= result_cnt;
      hits_o       <= hit_cnt;
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the page replacement engine: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int ClkHalf = 6;
  localparam int NumPhases = 12;
  localparam int PhaseItems = 75;
  // unused policy code, expected to act as FIFO
  localparam logic [1:0] PolSpare = 2'd3;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [pre_pkg::CfgIdxW-1:0]  cfg_index_i = pre_pkg::RegPolicy;
  logic [pre_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [pre_pkg::PageInW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [pre_pkg::OutDataW-1:0] m_axis_tdata;
  logic [pre_pkg::OutUserW-1:0] m_axis_tuser;

  int fail_count;
  int pending;
  int results;
  int hits;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sent = 0;

  always #(ClkHalf) clk_i = ~clk_i;

  page_replacement_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  page_ref_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .ref_valid_i  (s_axis_tvalid),
    .ref_ready_i  (s_axis_tready),
    .ref_page_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits)
  );

  // Result side back-pressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Present one reference, with random idle cycles ahead of it
  task automatic send_page(input logic [pre_pkg::PageInW-1:0] pg);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pg;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write both registers back to back; only called with the block idle
  task automatic set_mode(input logic [1:0] pol, input logic [3:0] nfr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= pre_pkg::RegPolicy;
    cfg_data_i  <= pre_pkg::CfgDataW'(pol);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index_i <= pre_pkg::RegFrames;
    cfg_data_i  <= nfr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [pre_pkg::PageInW-1:0] pool [16];
    int                          pool_len;
    int                          mode;
    logic [pre_pkg::PageInW-1:0] pg;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings (FIFO, eight frames), fill with extreme pages, then a hit
    send_page(16'h0000);
    send_page(16'hFFFF);
    for (int k = 1; k <= 6; k++) send_page(pre_pkg::PageInW'(k));
    send_page(16'hFFFF);
    // FIFO evictions move the head on to frame 4
    send_page(16'h1234);
    send_page(16'h4321);
    send_page(16'hAAAA);
    send_page(16'h5555);
    // shrink to two frames: head now out of range, upper frames keep their pages
    drain();
    set_mode(pre_pkg::POL_FIFO, 4'd2);
    send_page(16'h0F0F);
    // spare policy code and zero frames
    drain();
    set_mode(PolSpare, 4'd0);
    send_page(16'h00F0);
    send_page(16'h00F0);
    // LRU over an oversized frame count, stamps left by FIFO reinterpreted
    drain();
    set_mode(pre_pkg::POL_LRU, 4'd15);
    send_page(16'hAAAA);
    send_page(16'h0005);
    send_page(16'h7777);
    // LFU: counts build up on a hit, fresh pages start at zero, ties to lowest frame
    drain();
    set_mode(pre_pkg::POL_LFU, 4'd8);
    send_page(16'h0005);
    send_page(16'h0005);
    send_page(16'h8888);
    send_page(16'h8888);
    send_page(16'h9999);

    // Random phases: every policy code, a spread of frame settings, four idling modes
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      set_mode(2'(p % 4), 4'((p * 5 + 8) % 16));
      mode = (p / 3) % 4;
      case (mode)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      // a small working set gives a mix of hits and faults
      pool_len = $urandom_range(2, 16);
      for (int k = 0; k < 16; k++) pool[k] = pre_pkg::PageInW'($urandom_range(0, 65535));
      for (int k = 0; k < PhaseItems; k++) begin
        if (k == PhaseItems / 2) drain();
        if ($urandom_range(99) < 85) pg = pool[$urandom_range(0, pool_len - 1)];
        else pg = pre_pkg::PageInW'($urandom_range(0, 65535));
        send_page(pg);
      end
    end

    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (20) @(negedge clk_i);

    $display("Covered %0d page references, %0d results checked, %0d of them hits,",
             sent, results, hits);
    $display("under FIFO, LRU, LFU and the spare policy code, frame settings from 0 to 15.");
    if (fail_count == 0 && pending == 0 && results == sent) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(400_000 * 12);
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pre_pkg.sv
src/pre_cell.sv
src/page_replacement_engine.sv
test/page_ref_checker.sv
test/tb_top.sv
